/* sv/odtlc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// odtlc_pkg: shared types and constants of the traffic light controller
// Lamp word, phase encoding, configuration bundle and register indexes.
// ---------------------------------------------------------------------------
package odtlc_pkg;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_GREEN_TICKS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RED_TICKS       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WALK_TICKS      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON_TICKS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_OFF_TICKS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_CYCLES    = 3'd5;

	// Field widths
	localparam int unsigned TIMER_W = 16;
	localparam int unsigned BLINK_W = 12;
	localparam int unsigned CYC_W   = 4;
	localparam int unsigned STEP_W  = 2;

	// Reset values of the registers
	localparam logic [TIMER_W-1:0] GREEN_TICKS_RST     = 16'd10200;
	localparam logic [TIMER_W-1:0] RED_TICKS_RST       = 16'd3400;
	localparam logic [TIMER_W-1:0] WALK_TICKS_RST      = 16'd5000;
	localparam logic [BLINK_W-1:0] BLINK_ON_TICKS_RST  = 12'd380;
	localparam logic [BLINK_W-1:0] BLINK_OFF_TICKS_RST = 12'd180;
	localparam logic [CYC_W-1:0]   BLINK_CYCLES_RST    = 4'd5;

	// Segments of one on-off-on blink cycle
	localparam logic [STEP_W-1:0] STEP_ON_FIRST  = 2'd0;
	localparam logic [STEP_W-1:0] STEP_OFF       = 2'd1;
	localparam logic [STEP_W-1:0] STEP_ON_SECOND = 2'd2;

	typedef struct packed {
		logic [TIMER_W-1:0] green_ticks;
		logic [TIMER_W-1:0] red_ticks;
		logic [TIMER_W-1:0] walk_ticks;
		logic [BLINK_W-1:0] blink_on_ticks;
		logic [BLINK_W-1:0] blink_off_ticks;
		logic [CYC_W-1:0]   blink_cycles;
	} cfg_t;

	typedef struct packed {
		logic car_red;
		logic car_yellow;
		logic car_green;
		logic walk_red;
		logic walk_yellow;
		logic walk_green;
	} lamps_t;

	typedef enum logic [6:0] {
		PH_GREEN        = 7'b0000001,
		PH_YEL_TO_RED   = 7'b0000010,
		PH_RED          = 7'b0000100,
		PH_YEL_TO_GREEN = 7'b0001000,
		PH_PREP         = 7'b0010000,
		PH_WALK         = 7'b0100000,
		PH_FINAL        = 7'b1000000
	} phase_t;

endpackage

/* sv/odtlc_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// odtlc_core: phase sequencer of the traffic light controller
// Drives the lamps from the current state and advances the state once per
// accepted tick.
// ---------------------------------------------------------------------------
module odtlc_core
	import odtlc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   advance,
	input  logic   button_press,
	input  cfg_t   cfg,
	output lamps_t lamps
);

	typedef enum logic [1:0] {
		BLK_RUN   = 2'd0,
		BLK_CYCLE = 2'd1,
		BLK_LAST  = 2'd2
	} blink_res_t;

	phase_t             phase_q, phase_d;
	logic [TIMER_W-1:0] timer_q, timer_d;
	logic [CYC_W-1:0]   idx_q, idx_d;
	logic [STEP_W-1:0]  step_q, step_d;
	logic               req_q, req_d;

	logic               lit;
	logic               normal;
	logic               req_now;
	logic [TIMER_W:0]   tinc;
	logic [TIMER_W-1:0] len_sel;
	logic               t_done;
	logic [BLINK_W-1:0] blen;
	logic [CYC_W:0]     idx_inc;
	logic [TIMER_W-1:0] b_timer;
	logic [CYC_W-1:0]   b_idx;
	logic [STEP_W-1:0]  b_step;
	blink_res_t         b_res;
	logic               enter_en;
	phase_t             enter_ph;

	// Lamps show the state at the start of the tick
	assign lit = (step_q != STEP_OFF);

	always_comb begin
		lamps = '0;
		unique case (phase_q)
			PH_GREEN: begin
				lamps.car_green = 1'b1;
			end
			PH_YEL_TO_RED, PH_YEL_TO_GREEN: begin
				lamps.car_yellow = lit;
			end
			PH_RED: begin
				lamps.car_red = 1'b1;
			end
			PH_PREP: begin
				lamps.car_yellow  = lit;
				lamps.walk_yellow = lit;
				lamps.walk_red    = 1'b1;
			end
			PH_WALK: begin
				lamps.car_red    = 1'b1;
				lamps.walk_green = 1'b1;
			end
			PH_FINAL: begin
				lamps.car_yellow  = lit;
				lamps.walk_yellow = lit;
				lamps.walk_green  = 1'b1;
			end
			default: begin
				lamps = '0;
			end
		endcase
	end

	assign normal  = (phase_q == PH_GREEN) || (phase_q == PH_YEL_TO_RED) ||
	                 (phase_q == PH_RED) || (phase_q == PH_YEL_TO_GREEN);
	assign req_now = req_q | (button_press & normal);
	assign tinc    = {1'b0, timer_q} + 1'b1;

	// Duration of the timed phases
	always_comb begin
		unique case (phase_q)
			PH_RED:  len_sel = cfg.red_ticks;
			PH_WALK: len_sel = cfg.walk_ticks;
			default: len_sel = cfg.green_ticks;
		endcase
	end
	assign t_done = (tinc >= {1'b0, len_sel});

	// One tick of the blink counters
	assign blen    = (step_q == STEP_OFF) ? cfg.blink_off_ticks : cfg.blink_on_ticks;
	assign idx_inc = {1'b0, idx_q} + 1'b1;

	always_comb begin
		b_timer = timer_q;
		b_idx   = idx_q;
		b_step  = step_q;
		b_res   = BLK_RUN;
		if (tinc < {{(TIMER_W - BLINK_W + 1){1'b0}}, blen}) begin
			b_timer = tinc[TIMER_W-1:0];
		end else begin
			b_timer = '0;
			if (step_q != STEP_ON_SECOND) begin
				b_step = step_q + 1'b1;
			end else begin
				b_step = STEP_ON_FIRST;
				if (idx_inc >= {1'b0, cfg.blink_cycles}) begin
					b_res = BLK_LAST;
				end else begin
					b_idx = idx_inc[CYC_W-1:0];
					b_res = BLK_CYCLE;
				end
			end
		end
	end

	always_comb begin
		phase_d  = phase_q;
		timer_d  = timer_q;
		idx_d    = idx_q;
		step_d   = step_q;
		req_d    = req_now;
		enter_en = 1'b0;
		enter_ph = PH_GREEN;
		unique case (phase_q)
			PH_GREEN, PH_RED: begin
				if (req_now) begin
					enter_en = 1'b1;
					enter_ph = (phase_q == PH_GREEN) ? PH_PREP : PH_WALK;
				end else if (t_done) begin
					enter_en = 1'b1;
					enter_ph = (phase_q == PH_GREEN) ? PH_YEL_TO_RED : PH_YEL_TO_GREEN;
				end else begin
					timer_d = tinc[TIMER_W-1:0];
				end
			end
			PH_YEL_TO_RED, PH_YEL_TO_GREEN: begin
				timer_d = b_timer;
				idx_d   = b_idx;
				step_d  = b_step;
				if ((b_res != BLK_RUN) && req_now) begin
					enter_en = 1'b1;
					enter_ph = PH_PREP;
				end else if (b_res == BLK_LAST) begin
					enter_en = 1'b1;
					enter_ph = (phase_q == PH_YEL_TO_RED) ? PH_RED : PH_GREEN;
				end
			end
			PH_PREP: begin
				timer_d = b_timer;
				idx_d   = b_idx;
				step_d  = b_step;
				if (b_res == BLK_LAST) begin
					enter_en = 1'b1;
					enter_ph = PH_WALK;
				end
			end
			PH_WALK: begin
				if (t_done) begin
					enter_en = 1'b1;
					enter_ph = PH_FINAL;
				end else begin
					timer_d = tinc[TIMER_W-1:0];
				end
			end
			PH_FINAL: begin
				timer_d = b_timer;
				idx_d   = b_idx;
				step_d  = b_step;
				if (b_res == BLK_LAST) begin
					req_d    = 1'b0;
					enter_en = 1'b1;
					enter_ph = PH_GREEN;
				end
			end
			default: begin
				// Illegal phase code: recover to car green
				req_d    = 1'b0;
				enter_en = 1'b1;
				enter_ph = PH_GREEN;
			end
		endcase
		if (enter_en) begin
			phase_d = enter_ph;
			timer_d = '0;
			idx_d   = '0;
			step_d  = STEP_ON_FIRST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_GREEN;
			timer_q <= '0;
			idx_q   <= '0;
			step_q  <= STEP_ON_FIRST;
			req_q   <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			idx_q   <= idx_d;
			step_q  <= step_d;
			req_q   <= req_d;
		end
	end

endmodule

/* sv/odtlc_out_buf.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// odtlc_out_buf: result register with skid entry
// Holds the lamp word for the consumer; the upstream stall is registered.
// ---------------------------------------------------------------------------
module odtlc_out_buf
	import odtlc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  lamps_t push_data,
	output logic   full,
	output logic   out_valid,
	input  logic   out_stall,
	output lamps_t out_data
);

	logic   out_valid_q;
	lamps_t out_data_q;
	logic   skid_valid_q;
	lamps_t skid_data_q;
	logic   take;
	logic   out_free;

	assign take     = out_valid_q & ~out_stall;
	assign out_free = ~out_valid_q | take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q  <= skid_valid_q | push;
				skid_valid_q <= 1'b0;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* sv/on_demand_traffic_light_controller.sv */
`timescale 1ns / 1ps
// The lamp word of a tick goes into the result register, or into the skid entry while that register is stalled.
// Throughput: one tick per cycle while in_stall is low; the phase state updates in one pass at acceptance.
// in_stall rises only when both the result register and its skid entry hold words.
// Reset (arst_n low, asynchronous): car green, timers and button request cleared,
// output empty, configuration back to its default durations.
// ---------------------------------------------------------------------------
// on_demand_traffic_light_controller: car/pedestrian lights with push button
// Each accepted word is one millisecond tick with the button pulse; each
// tick gives one word with the six lamp states.
// ---------------------------------------------------------------------------
module on_demand_traffic_light_controller
	import odtlc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Tick input
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  button_press,
	// Lamp output
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  car_red,
	output logic                  car_yellow,
	output logic                  car_green,
	output logic                  walk_red,
	output logic                  walk_yellow,
	output logic                  walk_green,
	// Configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t   cfg_q;
	lamps_t lamps;
	lamps_t out_lamps;
	logic   accept;
	logic   buf_full;

	// Configuration registers; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.green_ticks     <= GREEN_TICKS_RST;
			cfg_q.red_ticks       <= RED_TICKS_RST;
			cfg_q.walk_ticks      <= WALK_TICKS_RST;
			cfg_q.blink_on_ticks  <= BLINK_ON_TICKS_RST;
			cfg_q.blink_off_ticks <= BLINK_OFF_TICKS_RST;
			cfg_q.blink_cycles    <= BLINK_CYCLES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GREEN_TICKS:     cfg_q.green_ticks     <= cfg_data[TIMER_W-1:0];
				CFG_RED_TICKS:       cfg_q.red_ticks       <= cfg_data[TIMER_W-1:0];
				CFG_WALK_TICKS:      cfg_q.walk_ticks      <= cfg_data[TIMER_W-1:0];
				CFG_BLINK_ON_TICKS:  cfg_q.blink_on_ticks  <= cfg_data[BLINK_W-1:0];
				CFG_BLINK_OFF_TICKS: cfg_q.blink_off_ticks <= cfg_data[BLINK_W-1:0];
				CFG_BLINK_CYCLES:    cfg_q.blink_cycles    <= cfg_data[CYC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Take a tick whenever the skid entry is free
	assign in_stall = buf_full;
	assign accept   = in_valid & ~buf_full;

	// Sequencer: lamps from the current state, advance on each accepted tick
	odtlc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (accept),
		.button_press (button_press),
		.cfg          (cfg_q),
		.lamps        (lamps)
	);

	// Result register plus skid entry toward the consumer
	odtlc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (lamps),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_lamps)
	);

	assign car_red     = out_lamps.car_red;
	assign car_yellow  = out_lamps.car_yellow;
	assign car_green   = out_lamps.car_green;
	assign walk_red    = out_lamps.walk_red;
	assign walk_yellow = out_lamps.walk_yellow;
	assign walk_green  = out_lamps.walk_green;

endmodule

/* sv/odtlc_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// odtlc_checker: port-level checks of the traffic light controller
// Buffer occupancy, handshake hold and lamp combinations.
// ---------------------------------------------------------------------------
module odtlc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic car_red,
	input logic car_yellow,
	input logic car_green,
	input logic walk_red,
	input logic walk_yellow,
	input logic walk_green
);

	// A full skid entry implies a waiting result word
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result word pending");

	// Every accepted tick leaves a result word pending
	a_accept_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted tick produced no result word");

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable({car_red, car_yellow,
			car_green, walk_red, walk_yellow, walk_green})))
		else $error("stalled result word changed");

	// At most one car lamp lit; walk green never with walk red or car green
	a_lamp_combo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (($countones({car_red, car_yellow, car_green}) <= 1) &&
			!(walk_green && walk_red) && !(walk_green && car_green)))
		else $error("conflicting lamps lit");

endmodule

bind on_demand_traffic_light_controller odtlc_checker u_odtlc_checker (.*);

/* tb/odtlc_lamp_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// odtlc_lamp_checker: lamp word predictor and scoreboard
// Follows the configuration writes, predicts the lamp word of every tick
// that the controller takes, and compares each lamp word that leaves it.
// ---------------------------------------------------------------------------
module odtlc_lamp_checker
	import odtlc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic                  button_press,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  car_red,
	input  logic                  car_yellow,
	input  logic                  car_green,
	input  logic                  walk_red,
	input  logic                  walk_yellow,
	input  logic                  walk_green,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    words_due
);

	typedef enum {BLINK_RUNNING, BLINK_CYCLE_DONE, BLINK_ALL_DONE} blink_event_t;

	cfg_t               timing;
	phase_t             phase;
	logic [TIMER_W-1:0] ticks;
	logic [CYC_W-1:0]   cycles_done;
	logic [STEP_W-1:0]  segment;
	logic               request;
	lamps_t             lamp_words_due[$];

	function automatic string lamp_label(int bit_pos);
		case (bit_pos)
			5: return "car_red";
			4: return "car_yellow";
			3: return "car_green";
			2: return "walk_red";
			1: return "walk_yellow";
			default: return "walk_green";
		endcase
	endfunction

	function automatic void go_to(phase_t next_phase);
		phase = next_phase;
		ticks = '0;
		cycles_done = '0;
		segment = STEP_ON_FIRST;
	endfunction

	// A length of zero behaves as one tick.
	function automatic bit timed_out(logic [TIMER_W-1:0] span);
		int unsigned next_count;
		next_count = ticks + 1;
		if (next_count >= span)
			return 1'b1;
		ticks = next_count[TIMER_W-1:0];
		return 1'b0;
	endfunction

	function automatic blink_event_t blink_tick();
		int unsigned span;
		int unsigned next_count;
		span = 32'((segment == STEP_OFF) ? timing.blink_off_ticks : timing.blink_on_ticks);
		next_count = ticks + 1;
		if (next_count < span) begin
			ticks = next_count[TIMER_W-1:0];
			return BLINK_RUNNING;
		end
		ticks = '0;
		if (segment != STEP_ON_SECOND) begin
			segment = (segment == STEP_ON_FIRST) ? STEP_OFF : STEP_ON_SECOND;
			return BLINK_RUNNING;
		end
		segment = STEP_ON_FIRST;
		if (cycles_done + 1 >= timing.blink_cycles)
			return BLINK_ALL_DONE;
		cycles_done = cycles_done + 1'b1;
		return BLINK_CYCLE_DONE;
	endfunction

	// Lamps show the state at the start of the tick; the state then advances.
	function automatic lamps_t advance_lights(logic press);
		lamps_t       shown;
		logic         lit;
		blink_event_t blink;
		shown = '0;
		lit = (segment != STEP_OFF);
		case (phase)
			PH_GREEN: shown.car_green = 1'b1;
			PH_YEL_TO_RED, PH_YEL_TO_GREEN: shown.car_yellow = lit;
			PH_RED: shown.car_red = 1'b1;
			PH_PREP: begin
				shown.car_yellow = lit;
				shown.walk_yellow = lit;
				shown.walk_red = 1'b1;
			end
			PH_WALK: begin
				shown.car_red = 1'b1;
				shown.walk_green = 1'b1;
			end
			PH_FINAL: begin
				shown.car_yellow = lit;
				shown.walk_yellow = lit;
				shown.walk_green = 1'b1;
			end
			default: ;
		endcase

		if (press && (phase == PH_GREEN || phase == PH_YEL_TO_RED ||
				phase == PH_RED || phase == PH_YEL_TO_GREEN))
			request = 1'b1;

		case (phase)
			PH_GREEN: begin
				if (request)
					go_to(PH_PREP);
				else if (timed_out(timing.green_ticks))
					go_to(PH_YEL_TO_RED);
			end
			PH_RED: begin
				if (request)
					go_to(PH_WALK);
				else if (timed_out(timing.red_ticks))
					go_to(PH_YEL_TO_GREEN);
			end
			PH_YEL_TO_RED, PH_YEL_TO_GREEN: begin
				blink = blink_tick();
				if (blink != BLINK_RUNNING && request)
					go_to(PH_PREP);
				else if (blink == BLINK_ALL_DONE)
					go_to((phase == PH_YEL_TO_RED) ? PH_RED : PH_GREEN);
			end
			PH_PREP: begin
				if (blink_tick() == BLINK_ALL_DONE)
					go_to(PH_WALK);
			end
			PH_WALK: begin
				if (timed_out(timing.walk_ticks))
					go_to(PH_FINAL);
			end
			PH_FINAL: begin
				if (blink_tick() == BLINK_ALL_DONE) begin
					request = 1'b0;
					go_to(PH_GREEN);
				end
			end
			default: begin
				request = 1'b0;
				go_to(PH_GREEN);
			end
		endcase
		return shown;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lamps_t seen;
		lamps_t due;
		if (!arst_n) begin
			timing.green_ticks = GREEN_TICKS_RST;
			timing.red_ticks = RED_TICKS_RST;
			timing.walk_ticks = WALK_TICKS_RST;
			timing.blink_on_ticks = BLINK_ON_TICKS_RST;
			timing.blink_off_ticks = BLINK_OFF_TICKS_RST;
			timing.blink_cycles = BLINK_CYCLES_RST;
			request = 1'b0;
			go_to(PH_GREEN);
			lamp_words_due.delete();
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_GREEN_TICKS: timing.green_ticks = cfg_data;
					CFG_RED_TICKS: timing.red_ticks = cfg_data;
					CFG_WALK_TICKS: timing.walk_ticks = cfg_data;
					CFG_BLINK_ON_TICKS: timing.blink_on_ticks = cfg_data[BLINK_W-1:0];
					CFG_BLINK_OFF_TICKS: timing.blink_off_ticks = cfg_data[BLINK_W-1:0];
					CFG_BLINK_CYCLES: timing.blink_cycles = cfg_data[CYC_W-1:0];
					default: ;
				endcase
			end

			if (out_valid && !out_stall) begin
				seen = {car_red, car_yellow, car_green, walk_red, walk_yellow, walk_green};
				if (lamp_words_due.size() == 0) begin
					mismatches++;
					$display("%0t: lamp word %b arrived with no tick pending", $time, seen);
				end else begin
					due = lamp_words_due.pop_front();
					for (int i = 5; i >= 0; i--) begin
						if (due[i] !== seen[i]) begin
							mismatches++;
							$display("%0t: %s expected %b got %b", $time, lamp_label(i),
								due[i], seen[i]);
						end
					end
				end
			end

			if (in_valid && !in_stall)
				lamp_words_due.push_back(advance_lights(button_press));
		end
		words_due = lamp_words_due.size();
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: traffic light controller with pedestrian button
// Feeds tick words with button pulses under several timing settings, with
// random gaps and output stalls; a checker beside the block predicts and
// compares every lamp word.
// ---------------------------------------------------------------------------
module testbench;
	import odtlc_pkg::*;

	// Button pattern of the directed run, one bit per tick, tick 0 in bit 0.
	// With the tiny timing below and the controller in green past its time:
	// red runs out into yellow, a press in yellow toward green ends it after
	// the blink, presses in prepare blink, walk and final blink are dropped,
	// and a press in green leaves green at once.
	localparam logic [25:0] DIRECTED_PRESSES = 26'b00000000_10101001_0001000000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic                  button_press;
	logic                  out_valid;
	logic                  out_stall;
	logic                  car_red;
	logic                  car_yellow;
	logic                  car_green;
	logic                  walk_red;
	logic                  walk_yellow;
	logic                  walk_green;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatches;
	int words_due;
	int lamp_words_taken;

	on_demand_traffic_light_controller u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.button_press (button_press),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.car_red      (car_red),
		.car_yellow   (car_yellow),
		.car_green    (car_green),
		.walk_red     (walk_red),
		.walk_yellow  (walk_yellow),
		.walk_green   (walk_green),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	odtlc_lamp_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.button_press (button_press),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.car_red      (car_red),
		.car_yellow   (car_yellow),
		.car_green    (car_green),
		.walk_red     (walk_red),
		.walk_yellow  (walk_yellow),
		.walk_green   (walk_green),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.words_due    (words_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one tick word. Called at a falling edge; returns at the falling
	// edge after the word was taken, with valid still high so that a
	// back-to-back word needs no second assignment in the same step.
	task automatic offer_tick(input logic press, input bit no_gaps);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			// drop valid and wiggle the button line while idle
			in_valid <= 1'b0;
			button_press <= 1'($urandom_range(0, 1));
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		button_press <= press;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drop valid, wait until every lamp word has come back, then let the
	// output stage go quiet before touching the registers.
	task automatic settle();
		in_valid <= 1'b0;
		button_press <= 1'($urandom_range(0, 1));
		while (words_due != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write all six timing registers on consecutive cycles, enable held high.
	task automatic program_timing(input int unsigned green_len, red_len,
			walk_len, blink_on, blink_off, blink_count);
		cfg_we <= 1'b1;
		cfg_index <= CFG_GREEN_TICKS;
		cfg_data <= green_len[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_index <= CFG_RED_TICKS;
		cfg_data <= red_len[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_index <= CFG_WALK_TICKS;
		cfg_data <= walk_len[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_index <= CFG_BLINK_ON_TICKS;
		cfg_data <= blink_on[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_index <= CFG_BLINK_OFF_TICKS;
		cfg_data <= blink_off[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_index <= CFG_BLINK_CYCLES;
		cfg_data <= blink_count[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random ticks: a press comes on average once every press_odds ticks.
	task automatic run_ticks(input int count, input int press_odds, input bit no_gaps);
		for (int i = 0; i < count; i++)
			offer_tick($urandom_range(1, press_odds) == 1, no_gaps);
		settle();
	endtask

	// Receiver: stall a random number of cycles before each lamp word, with
	// quiet stretches where it takes every word at once. Once, hold off for
	// a long stretch while the sender keeps going so the block backs up.
	initial begin
		int hold;
		bit quick;
		bit pressure_done;
		out_stall = 1'b0;
		lamp_words_taken = 0;
		quick = 1'b0;
		pressure_done = 1'b0;
		forever begin
			@(negedge clk);
			hold = quick ? 0 : $urandom_range(0, 15);
			if (!pressure_done && lamp_words_taken >= 150) begin
				hold = 64;
				pressure_done = 1'b1;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			lamp_words_taken++;
			if (lamp_words_taken % 32 == 0)
				quick = ($urandom_range(0, 2) == 0);
		end
	end

	// Stimulus and verdict.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		button_press = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_GREEN_TICKS;
		cfg_data = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// A few ticks on the default timing: green holds, nothing pressed.
		for (int i = 0; i < 4; i++)
			offer_tick(1'b0, 1'b0);
		settle();

		// Directed run on a tiny timing; green is already past its length.
		program_timing(2, 2, 2, 1, 1, 1);
		for (int i = 0; i < 26; i++)
			offer_tick(DIRECTED_PRESSES[i], 1'b0);
		settle();

		// Short random timing, frequent presses.
		program_timing($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
			$urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 2));
		run_ticks(85, 8, 1'b0);

		// All zero: every length acts as one tick or one blink cycle. Words
		// go back to back here, so the long output hold lands in this run.
		program_timing('0, '0, '0, '0, '0, '0);
		run_ticks(85, 6, 1'b1);

		// Longer timing and rare presses so the plain cycle runs through.
		program_timing($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 12),
			$urandom_range(1, 5), $urandom_range(1, 5), $urandom_range(1, 4));
		run_ticks(85, 40, 1'b0);

		// All ones on every register: the narrow ones keep only their low bits.
		program_timing('1, '1, '1, '1, '1, '1);
		run_ticks(20, 4, 1'b0);

		// Short timing with a press on average every other tick.
		program_timing($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
			$urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 3));
		run_ticks(85, 2, 1'b0);

		// Mixed timing, no sender gaps.
		program_timing($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
			$urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 3));
		run_ticks(90, 12, 1'b1);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
